/* hw/rtl/mfs_pkg.sv */
// Shared types, codes and constants of the metaball field shader.
package mfs_pkg;

    localparam int BALL_COUNT_DEF = 3;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int POS_W    = 12;
    localparam int VEL_W    = 5;
    localparam int RAD_W    = 6;
    localparam int PIX_W    = 10;
    localparam int COLOR_W  = 16;
    localparam int SUM_W    = 20;
    localparam int TERM_W   = SUM_W + 1;
    localparam int QUO_W    = SUM_W + 1;
    localparam int DIFF_W   = POS_W + 1;
    localparam int D2_W     = 2 * DIFF_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_SHADE   = 2'd2;

    localparam logic [1:0] SHADE_BACKDROP = 2'd0;
    localparam logic [1:0] SHADE_WEAK     = 2'd1;
    localparam logic [1:0] SHADE_MIDDLE   = 2'd2;
    localparam logic [1:0] SHADE_STRONG   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRONG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKDROP = 3'd5;

    localparam logic [TERM_W-1:0] TERM_CAP = TERM_W'(1) << SUM_W;
    localparam logic [SUM_W-1:0]  SUM_CAP  = '1;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [VEL_W-1:0] dx;
        logic signed [VEL_W-1:0] dy;
        logic        [RAD_W-1:0] r;
    } t_ball;

    typedef struct packed {
        logic             vld;
        logic [SUM_W-1:0] sum;
    } t_chain;

endpackage

/* hw/rtl/mfs_in_if.sv */
// Request channel of the metaball field shader.
interface mfs_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [3:0]        ball_index;
    logic signed [11:0] ball_x;
    logic signed [11:0] ball_y;
    logic signed [4:0] ball_dx;
    logic signed [4:0] ball_dy;
    logic [5:0]        ball_radius;
    logic [9:0]        pixel_x;
    logic [9:0]        pixel_y;

    modport source (output valid, op, ball_index, ball_x, ball_y, ball_dx, ball_dy,
                    ball_radius, pixel_x, pixel_y, input ready);
    modport sink (input valid, op, ball_index, ball_x, ball_y, ball_dx, ball_dy,
                  ball_radius, pixel_x, pixel_y, output ready);
endinterface

/* hw/rtl/mfs_out_if.sv */
// Result channel of the metaball field shader.
interface mfs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  shade;
    logic [15:0] pixel_color;
    logic [19:0] field_sum;

    modport source (output valid, shade, pixel_color, field_sum, input ready);
    modport sink (input valid, shade, pixel_color, field_sum, output ready);
endinterface

/* hw/rtl/mfs_cell.sv */
// One ball cell: holds a ball, moves it, divides its field term, adds to the chain.
module mfs_cell #(
    parameter int FRAC_BITS = mfs_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  mfs_pkg::t_ball               i_ball,
    input  logic                         i_adv,
    input  logic [mfs_pkg::PIX_W-1:0]    i_width,
    input  logic [mfs_pkg::PIX_W-1:0]    i_height,
    input  logic                         i_start,
    input  logic [mfs_pkg::PIX_W-1:0]    i_px,
    input  logic [mfs_pkg::PIX_W-1:0]    i_py,
    input  mfs_pkg::t_chain              i_chain,
    output mfs_pkg::t_chain              o_chain,
    output logic                         o_done
);
    import mfs_pkg::*;

    localparam int RR_W   = 2 * RAD_W;
    localparam int NUM_W  = (RR_W + FRAC_BITS > QUO_W) ? RR_W + FRAC_BITS : QUO_W + 1;
    localparam int HI_W   = NUM_W - QUO_W;
    localparam int REM_W  = D2_W + 1;
    localparam int CNT_W  = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    typedef enum logic [1:0] {S_IDLE, S_SQR, S_LOAD, S_DIV} t_state;

    t_state               r_state;
    t_ball                r_ball;
    logic signed [DIFF_W-1:0] r_ex, r_ey;
    logic [RR_W-1:0]      r_rr;
    logic [D2_W-1:0]      r_d2;
    logic [REM_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_low;
    logic [QUO_W-1:0]     r_q;
    logic                 r_sat;
    logic [CNT_W-1:0]     r_cnt;
    logic [TERM_W-1:0]    r_term;
    logic                 r_done;
    t_chain               r_out;

    logic signed [POS_W-1:0] n_x, n_y;
    logic signed [VEL_W-1:0] n_dx, n_dy;
    logic signed [D2_W-1:0]  sqx, sqy;
    logic [NUM_W-1:0]        num;
    logic [HI_W-1:0]         hi;
    logic [REM_W:0]          rem2;
    logic [REM_W:0]          d2_ext;
    logic                    take;
    logic [QUO_W-1:0]        q_next;
    logic [SUM_W+1:0]        acc;

    function automatic logic signed [VEL_W-1:0] neg_vel(input logic signed [VEL_W-1:0] v);
        logic signed [VEL_W-1:0] res;
        if (v == {1'b1, {(VEL_W-1){1'b0}}}) begin
            res = {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            res = -v;
        end
        return res;
    endfunction

    always_comb begin
        n_x  = r_ball.x + POS_W'(r_ball.dx);
        n_y  = r_ball.y + POS_W'(r_ball.dy);
        n_dx = r_ball.dx;
        n_dy = r_ball.dy;
        if (n_x < 0 || n_x > $signed({2'b00, i_width})) begin
            n_dx = neg_vel(r_ball.dx);
        end
        if (n_y < 0 || n_y > $signed({2'b00, i_height})) begin
            n_dy = neg_vel(r_ball.dy);
        end
    end

    assign sqx    = r_ex * r_ex;
    assign sqy    = r_ey * r_ey;
    assign num    = NUM_W'(r_rr) << FRAC_BITS;
    assign hi     = num[NUM_W-1:QUO_W];
    assign rem2   = {r_rem, r_low[QUO_W-1]};
    assign d2_ext = (REM_W+1)'(r_d2);
    assign take   = rem2 >= d2_ext;
    assign q_next = {r_q[QUO_W-2:0], take};
    assign acc    = (SUM_W+2)'(i_chain.sum) + (SUM_W+2)'(r_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ball  <= '0;
            r_done  <= 1'b0;
            r_out   <= '0;
        end else begin
            r_done    <= 1'b0;
            r_out.vld <= i_chain.vld;
            if (i_chain.vld) begin
                r_out.sum <= (acc > (SUM_W+2)'(SUM_CAP)) ? SUM_CAP : acc[SUM_W-1:0];
            end
            if (i_load) begin
                r_ball <= i_ball;
            end else if (i_adv) begin
                r_ball.x  <= n_x;
                r_ball.y  <= n_y;
                r_ball.dx <= n_dx;
                r_ball.dy <= n_dy;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ex    <= $signed({3'b000, i_px}) - $signed({r_ball.x[POS_W-1], r_ball.x});
                        r_ey    <= $signed({3'b000, i_py}) - $signed({r_ball.y[POS_W-1], r_ball.y});
                        r_rr    <= RR_W'(r_ball.r) * RR_W'(r_ball.r);
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_d2    <= D2_W'(unsigned'(sqx)) + D2_W'(unsigned'(sqy));
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // Zero distance or a quotient past the 21-bit window saturates.
                    r_sat   <= (r_d2 == '0) || (REM_W'(hi) >= REM_W'(r_d2));
                    r_rem   <= REM_W'(hi);
                    r_low   <= num[QUO_W-1:0];
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= take ? REM_W'(rem2 - d2_ext) : REM_W'(rem2);
                    r_low <= {r_low[QUO_W-2:0], 1'b0};
                    r_q   <= q_next;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_term  <= (r_sat || q_next[QUO_W-1]) ? TERM_CAP : TERM_W'(q_next);
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_chain = r_out;
    assign o_done  = r_done;

endmodule

/* hw/rtl/metaball_field_shader.sv */
// Top level of the metaball field shader: request decode, cell row and result register.
//
// The block keeps BALL_COUNT balls, one per cell in a row. A load request writes the
// cell that its index names, if any, and an advance request moves every ball at once;
// both are taken one per cycle while no shade request is in flight. A shade request
// starts all cells at once: each computes its squared distance to the pixel and then
// divides radius squared, scaled by 2^FRACTION_BITS, by that distance with a restoring
// divider that yields one quotient bit per cycle. Once the 21 quotient bits are done,
// the partial field sum walks down the row, each cell adding its saturated term in the
// cycle after its neighbor. A shade request's result is thus formed by the bit-serial
// divider in the cells and then the sum chain; no new request is taken until the result
// moves into the output register, where it sits, so the next request is accepted while
// it waits to be taken. The color comes from the registers in force when the result
// is formed. There is no clearing pass after reset.
module metaball_field_shader #(
    parameter int BALL_COUNT    = mfs_pkg::BALL_COUNT_DEF,
    parameter int FRACTION_BITS = mfs_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mfs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mfs_pkg::COLOR_W-1:0]       i_cfg_data,
    mfs_in_if.sink                            i_req,
    mfs_out_if.source                         o_res
);
    import mfs_pkg::*;

    // Thresholds keep all their bits, since with many fraction bits they exceed the sum.
    localparam int TH_W = (FRACTION_BITS + 1 > SUM_W) ? FRACTION_BITS + 1 : SUM_W;
    localparam logic [TH_W-1:0] TH_STRONG = TH_W'(((64'd1 << FRACTION_BITS) * 65) / 100);
    localparam logic [TH_W-1:0] TH_MIDDLE = TH_W'((64'd1 << FRACTION_BITS) / 2);
    localparam logic [TH_W-1:0] TH_WEAK   = TH_W'(((64'd1 << FRACTION_BITS) * 2) / 5);

    // Configuration registers.
    logic [PIX_W-1:0]   r_width, r_height;
    logic [COLOR_W-1:0] r_col_strong, r_col_middle, r_col_weak, r_col_backdrop;

    // Sequencing and result staging.
    logic               r_busy;
    logic               r_fin_vld;
    logic [SUM_W-1:0]   r_fin_sum;
    logic               r_o_vld;
    logic [1:0]         r_o_shade;
    logic [COLOR_W-1:0] r_o_color;
    logic [SUM_W-1:0]   r_o_sum;

    logic               req_acc;
    logic               do_load, do_adv, do_shade;
    logic               fin_move;
    logic [1:0]         n_shade;
    logic [COLOR_W-1:0] n_color;
    logic [TH_W-1:0]    fin_wide;
    t_ball              in_ball;
    t_chain             chain [BALL_COUNT+1];
    logic [BALL_COUNT-1:0] done;

    assign i_req.ready = !r_busy;
    assign req_acc     = i_req.valid && i_req.ready;
    assign do_load     = req_acc && (i_req.op == OP_LOAD);
    assign do_adv      = req_acc && (i_req.op == OP_ADVANCE);
    assign do_shade    = req_acc && (i_req.op == OP_SHADE);

    assign in_ball.x  = i_req.ball_x;
    assign in_ball.y  = i_req.ball_y;
    assign in_ball.dx = i_req.ball_dx;
    assign in_ball.dy = i_req.ball_dy;
    assign in_ball.r  = i_req.ball_radius;

    // The head of the chain starts from a zero sum as soon as the terms are ready.
    assign chain[0].vld = done[0];
    assign chain[0].sum = '0;

    for (genvar g = 0; g < BALL_COUNT; g++) begin : g_cell
        mfs_cell #(
            .FRAC_BITS (FRACTION_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (do_load && (32'(i_req.ball_index) == g)),
            .i_ball   (in_ball),
            .i_adv    (do_adv),
            .i_width  (r_width),
            .i_height (r_height),
            .i_start  (do_shade),
            .i_px     (i_req.pixel_x),
            .i_py     (i_req.pixel_y),
            .i_chain  (chain[g]),
            .o_chain  (chain[g+1]),
            .o_done   (done[g])
        );
    end

    assign fin_wide = TH_W'(r_fin_sum);

    // Thresholds are strict: a sum equal to a threshold falls to the lower shade.
    always_comb begin
        if (fin_wide > TH_STRONG) begin
            n_shade = SHADE_STRONG;
            n_color = r_col_strong;
        end else if (fin_wide > TH_MIDDLE) begin
            n_shade = SHADE_MIDDLE;
            n_color = r_col_middle;
        end else if (fin_wide > TH_WEAK) begin
            n_shade = SHADE_WEAK;
            n_color = r_col_weak;
        end else begin
            n_shade = SHADE_BACKDROP;
            n_color = r_col_backdrop;
        end
    end

    assign fin_move = r_fin_vld && (!r_o_vld || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width        <= PIX_W'(320);
            r_height       <= PIX_W'(240);
            r_col_strong   <= COLOR_W'(0);
            r_col_middle   <= COLOR_W'(65535);
            r_col_weak     <= COLOR_W'(2016);
            r_col_backdrop <= COLOR_W'(0);
            r_busy         <= 1'b0;
            r_fin_vld      <= 1'b0;
            r_o_vld        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:    r_width        <= i_cfg_data[PIX_W-1:0];
                    CFG_HEIGHT:   r_height       <= i_cfg_data[PIX_W-1:0];
                    CFG_STRONG:   r_col_strong   <= i_cfg_data;
                    CFG_MIDDLE:   r_col_middle   <= i_cfg_data;
                    CFG_WEAK:     r_col_weak     <= i_cfg_data;
                    CFG_BACKDROP: r_col_backdrop <= i_cfg_data;
                    default: ;
                endcase
            end
            if (do_shade) begin
                r_busy <= 1'b1;
            end
            if (chain[BALL_COUNT].vld) begin
                r_fin_vld <= 1'b1;
                r_fin_sum <= chain[BALL_COUNT].sum;
            end
            if (fin_move) begin
                r_fin_vld <= 1'b0;
                r_busy    <= 1'b0;
                r_o_vld   <= 1'b1;
                r_o_shade <= n_shade;
                r_o_color <= n_color;
                r_o_sum   <= r_fin_sum;
            end else if (o_res.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_o_vld;
    assign o_res.shade       = r_o_shade;
    assign o_res.pixel_color = r_o_color;
    assign o_res.field_sum   = r_o_sum;

    // All cells run in lockstep, so their divisions finish in the same cycle.
    a_cells_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done == '0) || (done == '1))
        else $error("cells finished out of step");

    // A finished sum only exists while a shade request is in flight.
    a_fin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_vld |-> r_busy)
        else $error("field sum staged with no shade request pending");

    // The end of the chain only fires for a request that is still in flight.
    a_chain_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain[BALL_COUNT].vld |-> (r_busy && !r_fin_vld))
        else $error("sum chain delivered with no request or a full stage");

endmodule

/* dv/metaball_field_shader_test.sv */
// Testbench of the metaball field shader: random and directed requests checked against a predictor.
module metaball_field_shader_test;
    import mfs_pkg::*;

    localparam int NBALLS = BALL_COUNT_DEF;
    localparam int FBITS  = FRAC_BITS_DEF;

    // One pending request as the driver puts it on the channel.
    typedef struct packed {
        logic [1:0]        op;
        logic [3:0]        idx;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic signed [4:0] dx;
        logic signed [4:0] dy;
        logic [5:0]        r;
        logic [9:0]        px;
        logic [9:0]        py;
    } t_req;

    // One expected pixel result.
    typedef struct packed {
        logic [1:0]  shade;
        logic [15:0] color;
        logic [19:0] sum;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [COLOR_W-1:0] i_cfg_data = '0;

    mfs_in_if  req_ch();
    mfs_out_if res_ch();

    metaball_field_shader uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(req_ch.sink), .o_res(res_ch.source)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Predictor state: the ball table and the registers as the block should hold them.
    t_ball       balls [NBALLS];
    logic [9:0]  scr_w, scr_h;
    logic [15:0] col_strong, col_middle, col_weak, col_backdrop;

    t_req   pending_reqs [$];
    t_pixel expected_pixels [$];
    int     mismatches = 0;
    int     pixels_seen = 0;
    int     reqs_sent = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    function automatic logic signed [4:0] flip_velocity(logic signed [4:0] v);
        // The most negative velocity has no positive twin and saturates.
        return (v == -5'sd16) ? 5'sd15 : -v;
    endfunction

    function automatic void move_balls();
        for (int i = 0; i < NBALLS; i++) begin
            balls[i].x = balls[i].x + 12'(signed'(balls[i].dx));
            balls[i].y = balls[i].y + 12'(signed'(balls[i].dy));
            if (balls[i].x < 0 || int'(balls[i].x) > int'(scr_w))
                balls[i].dx = flip_velocity(balls[i].dx);
            if (balls[i].y < 0 || int'(balls[i].y) > int'(scr_h))
                balls[i].dy = flip_velocity(balls[i].dy);
        end
    endfunction

    function automatic t_pixel shade_pixel(logic [9:0] px, logic [9:0] py);
        longint ex, ey, d2, term, total, one;
        t_pixel res;
        total = 0;
        one = longint'(1) << FBITS;
        for (int i = 0; i < NBALLS; i++) begin
            ex = longint'(px) - longint'(balls[i].x);
            ey = longint'(py) - longint'(balls[i].y);
            d2 = ex * ex + ey * ey;
            if (d2 == 0) begin
                term = longint'(1) << 20;
            end else begin
                term = ((longint'(balls[i].r) * longint'(balls[i].r)) << FBITS) / d2;
                if (term > (longint'(1) << 20)) term = longint'(1) << 20;
            end
            total += term;
            if (total > (longint'(1) << 20) - 1) total = (longint'(1) << 20) - 1;
        end
        res.sum = 20'(total);
        if (total > (one * 65) / 100) begin
            res.shade = SHADE_STRONG;   res.color = col_strong;
        end else if (total > one / 2) begin
            res.shade = SHADE_MIDDLE;   res.color = col_middle;
        end else if (total > (one * 2) / 5) begin
            res.shade = SHADE_WEAK;     res.color = col_weak;
        end else begin
            res.shade = SHADE_BACKDROP; res.color = col_backdrop;
        end
        return res;
    endfunction

    // Applies one accepted request to the predictor.
    function automatic void predict_request(t_req q);
        case (q.op)
            OP_LOAD: begin
                if (q.idx < NBALLS) balls[q.idx] = '{q.x, q.y, q.dx, q.dy, q.r};
            end
            OP_ADVANCE: move_balls();
            OP_SHADE: expected_pixels.push_back(shade_pixel(q.px, q.py));
            default: ;
        endcase
    endfunction

    // Driver: presents queued requests, idling at random with the current rate.
    logic have_req = 1'b0;
    initial begin
        req_ch.valid = 1'b0; req_ch.op = '0; req_ch.ball_index = '0; req_ch.ball_x = '0;
        req_ch.ball_y = '0; req_ch.ball_dx = '0; req_ch.ball_dy = '0;
        req_ch.ball_radius = '0; req_ch.pixel_x = '0; req_ch.pixel_y = '0;
        res_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        t_req q;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                predict_request(pending_reqs.pop_front());
                reqs_sent++;
            end
            // A valid request stays up until taken; a new one is only shown after.
            if (!(req_ch.valid && !req_ch.ready)) begin
                if (pending_reqs.size() > (req_ch.valid && req_ch.ready ? 0 : 0) &&
                    $urandom_range(99) >= send_idle_pct) begin
                    q = pending_reqs[0];
                    req_ch.valid       <= 1'b1;
                    req_ch.op          <= q.op;
                    req_ch.ball_index  <= q.idx;
                    req_ch.ball_x      <= q.x;
                    req_ch.ball_y      <= q.y;
                    req_ch.ball_dx     <= q.dx;
                    req_ch.ball_dy     <= q.dy;
                    req_ch.ball_radius <= q.r;
                    req_ch.pixel_x     <= q.px;
                    req_ch.pixel_y     <= q.py;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results with random stalls and checks each against the oldest prediction.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                pixels_seen++;
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel result shade=%0d color=%h sum=%h",
                                 res_ch.shade, res_ch.pixel_color, res_ch.field_sum);
                end else begin
                    want = expected_pixels.pop_front();
                    if (res_ch.shade !== want.shade || res_ch.pixel_color !== want.color ||
                        res_ch.field_sum !== want.sum) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: want %0d/%h/%h got %0d/%h/%h",
                                     want.shade, want.color, want.sum, res_ch.shade,
                                     res_ch.pixel_color, res_ch.field_sum);
                    end
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_req load_req(int idx, int x, int y, int dx, int dy, int r);
        t_req q;
        q = '0;
        q.op = OP_LOAD; q.idx = 4'(idx); q.x = 12'(x); q.y = 12'(y);
        q.dx = 5'(dx); q.dy = 5'(dy); q.r = 6'(r);
        return q;
    endfunction

    function automatic t_req shade_req(int px, int py);
        t_req q;
        q = t_req'($urandom());
        q.op = OP_SHADE; q.px = 10'(px); q.py = 10'(py);
        return q;
    endfunction

    function automatic t_req advance_req();
        t_req q;
        q = t_req'({$urandom(), $urandom(), $urandom()});
        q.op = OP_ADVANCE;
        return q;
    endfunction

    // Random request: advances, unknown ops, balls mostly placed near the screen and
    // pixels near them, so every shade level shows up; some loads and pixels are fully random.
    function automatic t_req random_req();
        t_req q;
        int k;
        k = $urandom_range(99);
        if (k < 20) begin
            q = load_req($urandom_range(3), $urandom_range(330) - 5, $urandom_range(250) - 5,
                         $urandom_range(31) - 16, $urandom_range(31) - 16, $urandom_range(63));
            if (k < 3) q = t_req'({$urandom(), $urandom(), $urandom()});
            if (k < 3) q.op = OP_LOAD;
        end else if (k < 30) begin
            q = advance_req();
        end else if (k < 32) begin
            q = t_req'({$urandom(), $urandom(), $urandom()});
            q.op = 2'd3;
        end else begin
            k = $urandom_range(NBALLS - 1);
            if ($urandom_range(9) < 7 && balls[k].x >= 0 && balls[k].y >= 0)
                q = shade_req(int'(balls[k].x) + $urandom_range(80) - 40,
                              int'(balls[k].y) + $urandom_range(80) - 40);
            else
                q = shade_req($urandom_range(1023), $urandom_range(1023));
            q.px = q.px; // negative offsets wrap within ten bits
        end
        return q;
    endfunction

    // Holds the write enable for one edge, then drops it before the task returns.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:    scr_w = val[9:0];
            CFG_HEIGHT:   scr_h = val[9:0];
            CFG_STRONG:   col_strong = val;
            CFG_MIDDLE:   col_middle = val;
            CFG_WEAK:     col_weak = val;
            CFG_BACKDROP: col_backdrop = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Waits until every request is taken and every result checked, then idles before returning.
    task automatic drain();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (24 + NBALLS + 8) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            // Items are predicted at acceptance, so the generator sees the table from before this phase.
            pending_reqs.push_back(random_req());
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < NBALLS; i++) balls[i] = '0;
        scr_w = 10'd320; scr_h = 10'd240;
        col_strong = 16'h0000; col_middle = 16'hFFFF; col_weak = 16'd2016;
        col_backdrop = 16'h0000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset table shading, extremes, bounces, saturation and ignored requests.
        pending_reqs.push_back(shade_req(0, 0));
        pending_reqs.push_back(shade_req(1023, 1023));
        pending_reqs.push_back(load_req(0, 100, 100, -16, 15, 63));
        pending_reqs.push_back(load_req(1, -2048, 2047, 15, -16, 0));
        pending_reqs.push_back(load_req(2, 2047, 0, 1, -1, 40));
        pending_reqs.push_back(load_req(3, 5, 5, 3, 3, 63));
        pending_reqs.push_back(load_req(15, 7, 7, 2, 2, 1));
        pending_reqs.push_back(shade_req(100, 100));
        pending_reqs.push_back(shade_req(110, 100));
        pending_reqs.push_back(shade_req(180, 100));
        pending_reqs.push_back(shade_req(1023, 0));
        pending_reqs.push_back(advance_req());
        pending_reqs.push_back(advance_req());
        pending_reqs.push_back(shade_req(84, 115));
        pending_reqs.push_back(load_req(0, 0, 0, -16, -16, 63));
        pending_reqs.push_back(advance_req());
        pending_reqs.push_back(shade_req(15, 15));
        begin
            t_req q;
            q = shade_req(0, 0);
            q.op = 2'd3;
            pending_reqs.push_back(q);
        end
        pending_reqs.push_back(shade_req(60, 0));
        drain();

        write_reg(CFG_WIDTH, 16'hFC01);
        write_reg(CFG_HEIGHT, 16'd1023);
        write_reg(CFG_STRONG, 16'hF800);
        write_reg(CFG_MIDDLE, 16'h07E0);
        write_reg(CFG_WEAK, 16'h001F);
        write_reg(CFG_BACKDROP, 16'hFFFF);
        write_reg(3'd7, 16'h1234);
        random_phase(350, 0, 0);

        write_reg(CFG_WIDTH, 16'd1023);
        write_reg(CFG_HEIGHT, 16'd1);
        write_reg(CFG_STRONG, 16'(($urandom())));
        write_reg(CFG_BACKDROP, 16'h0000);
        random_phase(350, 60, 0);

        write_reg(CFG_WIDTH, 16'd0);
        write_reg(CFG_HEIGHT, 16'd0);
        write_reg(CFG_MIDDLE, 16'(($urandom())));
        random_phase(350, 0, 60);

        write_reg(CFG_WIDTH, 16'd320);
        write_reg(CFG_HEIGHT, 16'd240);
        write_reg(CFG_WEAK, 16'(($urandom())));
        random_phase(380, 20, 20);

        $display("ran %0d requests over four idle mixes and checked %0d pixel results",
                 reqs_sent, pixels_seen);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(12 * 2000000);
        $display("tb: failure");
        $finish;
    end
endmodule
